// ===== src/tksp_pkg.sv =====
// tksp_pkg: shared operation codes for the top-k score pruner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tksp_pkg;
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;
endpackage
`default_nettype wire

// ===== src/top_k_score_pruner_top.sv =====
// top_k_score_pruner_top: beam store with lazy top-k pruning by insertion sort
// depends on tksp_pkg and tksp_store
//
// channel   direction  ports
// command   in         start_i, busy_o, operation_i, score_i, item_tag_i, read_index_i
// result    out        done_o, accepted_o .. read_valid_o
// config    in         cfg_we_i, cfg_data_i
//
// a read passes through S_RDWAIT and S_RDOUT, a plain add through S_CHK, before the done strobe
// an add that leaves more than twice the keep count held runs an insertion sort
// over the store's write and read ports: S_OUTER, S_RKEY and S_RPREV per entry,
// then S_CMP for each shift, before S_RWORST and S_WORST cut the store to keep
// reset clears the sequencer and result registers; the store is undefined until written
// results cannot be stalled; done_o is high for one cycle
`timescale 1ns / 1ps
`default_nettype none
module top_k_score_pruner_top
  import tksp_pkg::*;
#(
  parameter int unsigned MAX_KEPT = 256,
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  operation_i,
  input  wire logic [SCORE_BITS-1:0] score_i,
  input  wire logic [TAG_BITS-1:0]   item_tag_i,
  input  wire logic [9:0]            read_index_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [8:0]            cfg_data_i,
  output logic                       done_o,
  output logic                       accepted_o,
  output logic [9:0]                 count_held_o,
  output logic [31:0]                best_score_o,
  output logic                       best_valid_o,
  output logic [31:0]                worst_threshold_o,
  output logic                       threshold_valid_o,
  output logic [31:0]                total_pruned_o,
  output logic [31:0]                read_score_o,
  output logic [15:0]                read_tag_o,
  output logic                       read_valid_o
);
  localparam int unsigned DEPTH = 2 * MAX_KEPT + 1;
  localparam int unsigned AW = $clog2(DEPTH + 1);
  localparam int unsigned KW = $clog2(MAX_KEPT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_RDOUT, S_CHK, S_OUTER, S_RKEY, S_RPREV, S_CMP, S_PLACE,
    S_RWORST, S_WORST, S_DONE
  } state_e;

  state_e            state_q;
  logic [8:0]        maxk_q;
  logic [AW-1:0]     held_q, i_q, j_q;
  logic [SCORE_BITS-1:0] best_q, worst_q, key_s_q;
  logic [TAG_BITS-1:0]   key_t_q;
  logic              best_v_q, worst_v_q, acc_q, rv_q;
  logic [31:0]       pruned_q;
  logic [9:0]        ridx_q;
  logic [KW-1:0]     keep_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [SCORE_BITS-1:0] wscore, rscore;
  logic [TAG_BITS-1:0]   wtag, rtag;

  tksp_store #(.AW(AW), .DEPTH(DEPTH), .SW(SCORE_BITS), .TW(TAG_BITS)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wscore_i(wscore), .wtag_i(wtag),
    .raddr_i(raddr), .rscore_o(rscore), .rtag_o(rtag)
  );

  // effective keep count, clamped to 1..MAX_KEPT
  logic [KW-1:0] keep_eff;
  always_comb begin
    if (maxk_q == 9'd0) keep_eff = KW'(1);
    else if ({23'd0, maxk_q} > MAX_KEPT) keep_eff = KW'(MAX_KEPT);
    else keep_eff = KW'(maxk_q);
  end

  logic add_rej, add_room;
  assign add_rej  = worst_v_q && ($signed(score_i) < $signed(worst_q));
  assign add_room = {{(32-AW){1'b0}}, held_q} < DEPTH;

  // memory port control
  always_comb begin
    we = 1'b0; waddr = held_q; wscore = score_i; wtag = item_tag_i;
    raddr = i_q;
    case (state_q)
      S_IDLE: begin
        we = start_i && operation_i == OP_ADD && !add_rej && add_room;
        raddr = AW'(read_index_i);
      end
      S_RDWAIT: raddr = AW'(ridx_q);
      S_RDOUT:  raddr = AW'(ridx_q);
      S_OUTER: raddr = i_q;
      S_RKEY:  raddr = j_q - AW'(1);
      S_RPREV: raddr = j_q - AW'(1);
      S_CMP: begin
        // shift previous entry up, or drop the key in place
        we = 1'b1; waddr = j_q;
        if ($signed(rscore) < $signed(key_s_q) && j_q != '0) begin
          wscore = rscore; wtag = rtag;
        end else begin
          wscore = key_s_q; wtag = key_t_q;
        end
        raddr = j_q - AW'(2);
      end
      S_RWORST: raddr = AW'(keep_q) - AW'(1);
      default: ;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

  // sequencer with state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; maxk_q <= 9'd256; held_q <= '0; best_q <= '0;
      best_v_q <= 1'b0; worst_q <= '0; worst_v_q <= 1'b0; pruned_q <= '0;
      done_o <= 1'b0; acc_q <= 1'b0; rv_q <= 1'b0; i_q <= '0; j_q <= '0;
      ridx_q <= '0; keep_q <= '0; key_s_q <= '0; key_t_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) maxk_q <= cfg_data_i;
      case (state_q)
        S_IDLE: if (start_i) begin
          keep_q <= keep_eff;
          acc_q <= 1'b0; rv_q <= 1'b0; ridx_q <= read_index_i;
          if (operation_i == OP_READ) state_q <= S_RDWAIT;
          else begin
            if (add_rej) begin
              if (pruned_q != 32'hFFFF_FFFF) pruned_q <= pruned_q + 32'd1;
            end else if (add_room) begin
              held_q <= held_q + AW'(1); acc_q <= 1'b1;
              if (!best_v_q || $signed(score_i) > $signed(best_q)) begin
                best_q <= score_i; best_v_q <= 1'b1;
              end
            end
            state_q <= S_CHK;
          end
        end
        S_RDWAIT: state_q <= S_RDOUT;
        S_RDOUT: begin
          rv_q <= 32'(ridx_q) < 32'(held_q);
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        S_CHK: begin
          if ({{(32-AW){1'b0}}, held_q} > 2 * {{(32-KW){1'b0}}, keep_q}) begin
            i_q <= AW'(1); state_q <= S_OUTER;
          end else begin
            done_o <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_OUTER: begin
          if (i_q >= held_q) state_q <= S_RWORST;
          else begin j_q <= i_q; state_q <= S_RKEY; end
        end
        S_RKEY: begin
          key_s_q <= rscore; key_t_q <= rtag; state_q <= S_RPREV;
        end
        S_RPREV: state_q <= S_CMP;
        S_CMP: begin
          if ($signed(rscore) < $signed(key_s_q) && j_q != '0) begin
            j_q <= j_q - AW'(1);
            state_q <= (j_q == AW'(1)) ? S_PLACE : S_CMP;
          end else begin
            i_q <= i_q + AW'(1); state_q <= S_OUTER;
          end
        end
        S_PLACE: state_q <= S_CMP;
        S_RWORST: state_q <= S_WORST;
        S_WORST: begin
          worst_q <= rscore; worst_v_q <= 1'b1;
          if (32'(held_q - AW'(keep_q)) > 32'hFFFF_FFFF - pruned_q)
            pruned_q <= 32'hFFFF_FFFF;
          else pruned_q <= pruned_q + 32'(held_q - AW'(keep_q));
          held_q <= AW'(keep_q);
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result word
  assign accepted_o        = acc_q;
  assign count_held_o      = 10'(held_q);
  assign best_score_o      = best_v_q ? 32'(best_q) : 32'd0;
  assign best_valid_o      = best_v_q;
  assign worst_threshold_o = worst_v_q ? 32'(worst_q) : 32'd0;
  assign threshold_valid_o = worst_v_q;
  assign total_pruned_o    = pruned_q;
  assign read_score_o      = rv_q ? 32'(rscore) : 32'd0;
  assign read_tag_o        = rv_q ? 16'(rtag) : 16'd0;
  assign read_valid_o      = rv_q;
endmodule
`default_nettype wire

// ===== src/tksp_store.sv =====
// tksp_store: score and tag memory, one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module tksp_store #(
  parameter int unsigned AW = 10,
  parameter int unsigned DEPTH = 513,
  parameter int unsigned SW = 32,
  parameter int unsigned TW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [SW-1:0] wscore_i,
  input  wire logic [TW-1:0] wtag_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [SW-1:0] rscore_o,
  output logic      [TW-1:0] rtag_o
);
  logic [SW-1:0] score_mem [DEPTH];
  logic [TW-1:0] tag_mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      score_mem[waddr_i] <= wscore_i;
      tag_mem[waddr_i]   <= wtag_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rscore_o <= score_mem[raddr_i];
    rtag_o   <= tag_mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sim/top_k_score_pruner_top_tb.sv =====
// top_k_score_pruner_top_tb: self-checking bench for the top-k score pruner
// depends on tksp_pkg and top_k_score_pruner_top; predicts every result word
`timescale 1ns / 1ps
`default_nettype none
module top_k_score_pruner_top_tb
  import tksp_pkg::*;
;

  localparam int unsigned BEAM_MAX = 256;
  localparam int unsigned SLOTS = 2 * BEAM_MAX + 1;

  typedef struct packed {
    logic        accepted;
    logic [9:0]  count_held;
    logic [31:0] best_score;
    logic        best_valid;
    logic [31:0] worst_threshold;
    logic        threshold_valid;
    logic [31:0] total_pruned;
    logic [31:0] read_score;
    logic [15:0] read_tag;
    logic        read_valid;
  } beam_word_t;

  typedef struct {
    logic        op;
    logic [31:0] score;
    logic [15:0] tag;
    logic [9:0]  idx;
    int          known_count;  // -1 when only the predictor knows
    int          known_rvalid; // -1 when only the predictor knows
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        operation_i = OP_ADD;
  logic [31:0] score_i = '0;
  logic [15:0] item_tag_i = '0;
  logic [9:0]  read_index_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        busy_o, done_o, accepted_o, best_valid_o, threshold_valid_o, read_valid_o;
  logic [9:0]  count_held_o;
  logic [31:0] best_score_o, worst_threshold_o, total_pruned_o, read_score_o;
  logic [15:0] read_tag_o;

  top_k_score_pruner_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .score_i, .item_tag_i,
    .read_index_i, .cfg_we_i, .cfg_data_i, .done_o, .accepted_o, .count_held_o,
    .best_score_o, .best_valid_o, .worst_threshold_o, .threshold_valid_o,
    .total_pruned_o, .read_score_o, .read_tag_o, .read_valid_o
  );

  always #4 clk_i = ~clk_i;

  // shadow beam state
  logic signed [31:0] beam_score [SLOTS];
  logic [15:0]        beam_tag [SLOTS];
  int unsigned        beam_held = 0;
  logic signed [31:0] beam_best = '0;
  bit                 beam_best_ok = 0;
  logic signed [31:0] beam_floor = '0;
  bit                 beam_floor_ok = 0;
  logic [31:0]        beam_dropped = '0;
  logic [8:0]         keep_reg = 9'd256;

  beam_word_t pending_words[$];
  int         fail_count = 0;
  int         burst_left = 0;

  // stable descending sort, cut to keep entries
  function automatic void cut_beam(int unsigned keep);
    logic signed [31:0] s;
    logic [15:0]        t;
    int                 j;
    for (int i = 1; i < beam_held; i++) begin
      s = beam_score[i];
      t = beam_tag[i];
      j = i;
      while (j > 0 && beam_score[j-1] < s) begin
        beam_score[j] = beam_score[j-1];
        beam_tag[j] = beam_tag[j-1];
        j--;
      end
      beam_score[j] = s;
      beam_tag[j] = t;
    end
    beam_floor = beam_score[keep-1];
    beam_floor_ok = 1;
    if (64'(beam_dropped) + 64'(beam_held - keep) > 64'hFFFF_FFFF) beam_dropped = '1;
    else beam_dropped = beam_dropped + (beam_held - keep);
    beam_held = keep;
  endfunction

  function automatic beam_word_t beam_step(logic op, logic signed [31:0] s, logic [15:0] t,
                                           logic [9:0] idx);
    beam_word_t  w;
    int unsigned keep;
    w = '0;
    if (op == OP_ADD) begin
      keep = (keep_reg == 0) ? 1 : (keep_reg > BEAM_MAX ? BEAM_MAX : keep_reg);
      if (beam_floor_ok && s < beam_floor) begin
        if (beam_dropped != '1) beam_dropped++;
      end else if (beam_held < SLOTS) begin
        beam_score[beam_held] = s;
        beam_tag[beam_held] = t;
        beam_held++;
        w.accepted = 1'b1;
        if (!beam_best_ok || s > beam_best) begin
          beam_best = s;
          beam_best_ok = 1;
        end
      end
      if (beam_held > 2 * keep) cut_beam(keep);
    end else if (idx < beam_held) begin
      w.read_valid = 1'b1;
      w.read_score = beam_score[idx];
      w.read_tag = beam_tag[idx];
    end
    w.count_held = beam_held[9:0];
    w.best_score = beam_best_ok ? beam_best : '0;
    w.best_valid = beam_best_ok;
    w.worst_threshold = beam_floor_ok ? beam_floor : '0;
    w.threshold_valid = beam_floor_ok;
    w.total_pruned = beam_dropped;
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result word checker
  always @(posedge clk_i) begin
    beam_word_t w;
    if (done_o) begin
      if (pending_words.size() == 0) begin
        $error("done_o: expected no word, got one");
        fail_count++;
      end else begin
        w = pending_words.pop_front();
        check_field("accepted", w.accepted, accepted_o);
        check_field("count_held", w.count_held, count_held_o);
        check_field("best_score", w.best_score, best_score_o);
        check_field("best_valid", w.best_valid, best_valid_o);
        check_field("worst_threshold", w.worst_threshold, worst_threshold_o);
        check_field("threshold_valid", w.threshold_valid, threshold_valid_o);
        check_field("total_pruned", w.total_pruned, total_pruned_o);
        check_field("read_score", w.read_score, read_score_o);
        check_field("read_tag", w.read_tag, read_tag_o);
        check_field("read_valid", w.read_valid, read_valid_o);
      end
    end
  end

  // issue one command word, then maybe idle between bursts
  task automatic issue(cmd_row_t r);
    beam_word_t w;
    int         gap;
    start_i <= 1'b1;
    operation_i <= r.op;
    score_i <= r.score;
    item_tag_i <= r.tag;
    read_index_i <= r.idx;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    w = beam_step(r.op, r.score, r.tag, r.idx);
    if (r.known_count >= 0 && w.count_held != r.known_count) begin
      $error("count_held: expected %0d, got %0d", r.known_count, w.count_held);
      fail_count++;
    end
    if (r.known_rvalid >= 0 && w.read_valid != r.known_rvalid) begin
      $error("read_valid: expected %0d, got %0d", r.known_rvalid, w.read_valid);
      fail_count++;
    end
    pending_words = {pending_words, w};
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end else burst_left--;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // let the block go idle, then write max_kept
  task automatic write_keep(logic [8:0] v);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keep_reg = v;
  endtask

  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(($signed($urandom_range(0, 4)) - 2) * 65536);
      2: return beam_floor + $urandom_range(0, 6) - 3;
      default:
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return '0;
        endcase
    endcase
  endfunction

  task automatic random_phase(int n);
    cmd_row_t r;
    for (int i = 0; i < n; i++) begin
      r.op = ($urandom_range(0, 99) < 85) ? OP_ADD : OP_READ;
      r.score = pick_score();
      r.tag = 16'($urandom);
      r.idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, beam_held + 1)) : 10'($urandom);
      r.known_count = -1;
      r.known_rvalid = -1;
      issue(r);
    end
  endtask

  // directed rows at reset: empty reads, extreme scores, reads past the end
  cmd_row_t opening_rows [10] = '{
    '{OP_READ, 32'h0, 16'h0, 10'd0, 0, 0},
    '{OP_ADD, 32'h7FFF_FFFF, 16'hFFFF, 10'h3FF, 1, 0},
    '{OP_ADD, 32'h8000_0000, 16'h0000, 10'd0, 2, 0},
    '{OP_ADD, 32'h0000_0000, 16'h5A5A, 10'd0, 3, 0},
    '{OP_ADD, 32'hFFFF_FFFF, 16'hA5A5, 10'd0, 4, 0},
    '{OP_ADD, 32'h7FFF_FFFF, 16'h1234, 10'd0, 5, 0},
    '{OP_READ, 32'h0, 16'h0, 10'd0, 5, 1},
    '{OP_READ, 32'h0, 16'h0, 10'd4, 5, 1},
    '{OP_READ, 32'h0, 16'h0, 10'd5, 5, 0},
    '{OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 5, 0}
  };

  // prune rows at max_kept 1: ties with the threshold and a score below it
  cmd_row_t prune_rows [7] = '{
    '{OP_ADD, 32'h0001_0000, 16'h0001, 10'd0, 1, -1},
    '{OP_READ, 32'h0, 16'h0, 10'd0, 1, 1},
    '{OP_ADD, 32'h7FFF_FFFF, 16'h0002, 10'd0, 2, -1},
    '{OP_ADD, 32'h8000_0000, 16'h0003, 10'd0, 2, -1},
    '{OP_ADD, 32'h7FFF_FFFF, 16'h0004, 10'd0, 1, -1},
    '{OP_READ, 32'h0, 16'h0, 10'd0, 1, 1},
    '{OP_READ, 32'h0, 16'h0, 10'd1, 1, 0}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_rows[i]) issue(opening_rows[i]);
    write_keep(9'd1);
    foreach (prune_rows[i]) issue(prune_rows[i]);
    random_phase(60);
    write_keep(9'd0);
    random_phase(50);
    write_keep(9'd3);
    random_phase(60);
    // top of range acts as the full beam
    write_keep(9'd511);
    random_phase(560);
    write_keep(9'd300);
    random_phase(20);
    // lowering to 2 prunes on the next add if more than four entries are held
    write_keep(9'd2);
    random_phase(60);
    write_keep(9'd8);
    random_phase(60);
    write_keep(9'd256);
    random_phase(40);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
src/tksp_pkg.sv
src/tksp_store.sv
src/top_k_score_pruner_top.sv
sim/top_k_score_pruner_top_tb.sv
